@@ rtl/adaptive_ema_loop_current_scaler_defines.svh @@
// assertion macros shared by the loop-current scaler rtl
// expects signals named clock and reset in the module that uses them
`ifndef ADAPTIVE_EMA_LOOP_CURRENT_SCALER_DEFINES_SVH
`define ADAPTIVE_EMA_LOOP_CURRENT_SCALER_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define AELCS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define AELCS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/aelcs_pkg.sv @@
// shared types and constants for the adaptive ema loop-current scaler
// no dependencies
`timescale 1ns / 1ps

package aelcs_pkg;

   // fixed-point widths
   localparam int SampleWidth = 16;              // q8.8 ma
   localparam int FiltWidth   = 24;              // q8.16 ma
   localparam int GainWidth   = 9;
   localparam int DistWidth   = 11;
   localparam int CsrAddrWidth = 3;

   // register indexes on the csr port
   localparam logic [CsrAddrWidth-1:0] CSR_TIER_HIGH = 3'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_TIER_MID  = 3'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_TIER_LOW  = 3'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_GAIN_FAST = 3'd3;
   localparam logic [CsrAddrWidth-1:0] CSR_GAIN_MID  = 3'd4;
   localparam logic [CsrAddrWidth-1:0] CSR_GAIN_SMALL = 3'd5;
   localparam logic [CsrAddrWidth-1:0] CSR_GAIN_TINY = 3'd6;
   localparam logic [CsrAddrWidth-1:0] CSR_OFFSET    = 3'd7;

   // range limits in q8.8 ma
   localparam logic signed [15:0] Q_UNDER_LIMIT = 16'sd948;   // 3.7 ma
   localparam logic signed [15:0] Q_SPAN_LOW    = 16'sd1024;  // 4 ma
   localparam logic signed [15:0] Q_SPAN_HIGH   = 16'sd5120;  // 20 ma
   localparam logic signed [15:0] Q_OVER_LIMIT  = 16'sd5632;  // 22 ma

   // output scaling
   localparam logic [DistWidth-1:0] MM_LOW  = 11'd100;
   localparam logic [DistWidth-1:0] MM_SPAN = 11'd1900;
   localparam logic [DistWidth-1:0] MM_UNDER = 11'd0;
   localparam logic [DistWidth-1:0] MM_OVER  = 11'd1;

   // range status codes
   typedef enum logic [1:0] {
      RANGE_OK    = 2'd0,
      RANGE_UNDER = 2'd1,
      RANGE_OVER  = 2'd2
   } range_type;

   // filter configuration as seen by the back end
   typedef struct packed {
      logic [15:0]          tier_high;
      logic [15:0]          tier_mid;
      logic [15:0]          tier_low;
      logic [GainWidth-1:0] gain_fast;
      logic [GainWidth-1:0] gain_mid;
      logic [GainWidth-1:0] gain_small;
      logic [GainWidth-1:0] gain_tiny;
      logic signed [15:0]   offset;
   } cfg_type;

   // register values after reset
   localparam cfg_type CFG_RESET = '{
      tier_high:  16'd256,
      tier_mid:   16'd77,
      tier_low:   16'd26,
      gain_fast:  9'd243,
      gain_mid:   9'd205,
      gain_small: 9'd26,
      gain_tiny:  9'd13,
      offset:     16'sd90
   };

endpackage

@@ rtl/aelcs_front.sv @@
// front end: input register that takes samples and widens them to q8.16
// depends on aelcs_pkg
`timescale 1ns / 1ps

module aelcs_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [aelcs_pkg::SampleWidth-1:0] in_sample,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [aelcs_pkg::FiltWidth-1:0] out_x
);

   logic                                      vld_ff, vld_in;
   logic signed [aelcs_pkg::SampleWidth-1:0]  smp_ff, smp_in;
   logic                                      take, push;

   // handshakes
   assign push     = vld_ff && out_ready;
   assign in_ready = !vld_ff || out_ready;
   assign take     = in_valid && in_ready;

   // next state
   always_comb begin
      vld_in = vld_ff;
      smp_in = smp_ff;
      if (take) begin
         vld_in = 1'b1;
         smp_in = in_sample;
      end else if (push) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      smp_ff <= smp_in;
   end

   // q8.8 to q8.16
   assign out_valid = vld_ff;
   assign out_x     = {smp_ff, 8'h00};

endmodule

@@ rtl/aelcs_fifo.sv @@
// two-entry queue between the front end and the filter
// depends on aelcs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "adaptive_ema_loop_current_scaler_defines.svh"

module aelcs_fifo (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [aelcs_pkg::FiltWidth-1:0] in_x,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [aelcs_pkg::FiltWidth-1:0] out_x
);

   logic signed [aelcs_pkg::FiltWidth-1:0] mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   // full and empty come from the registered count
   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_x     = mem[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_x;
      end
   end

   `AELCS_ASSERT_IMP(a_cnt_max, 1'b1, cnt_ff != 2'd3, "queue count out of range")
   `AELCS_ASSERT_NXT(a_cnt_up, push && !pop, cnt_ff == $past(cnt_ff) + 2'd1, "queue count lost a push")

endmodule

@@ rtl/aelcs_filter.sv @@
// back end filter: tier select, adaptive gain step and state saturation
// depends on aelcs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "adaptive_ema_loop_current_scaler_defines.svh"

module aelcs_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  aelcs_pkg::cfg_type                     cfg,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [aelcs_pkg::FiltWidth-1:0] in_x,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [aelcs_pkg::FiltWidth-1:0] out_fv
);

   logic                                   vld_ff, vld_in;
   logic signed [aelcs_pkg::FiltWidth-1:0] fv_ff, fv_in;
   logic                                   pop;
   logic signed [24:0]                     diff;
   logic [24:0]                            mag;
   logic [aelcs_pkg::GainWidth-1:0]        gain;
   logic signed [34:0]                     prod;
   logic signed [34:0]                     rnd;
   logic signed [26:0]                     step;
   logic signed [27:0]                     sum;

   assign pop      = in_valid && in_ready;
   assign in_ready = !vld_ff || out_ready;

   // change against the filtered value, full precision
   assign diff = {in_x[23], in_x} - {fv_ff[23], fv_ff};
   assign mag  = diff[24] ? 25'(-diff) : 25'(diff);

   // tier select, first match wins
   always_comb begin
      priority if (mag > {1'b0, cfg.tier_high, 8'h00}) begin
         gain = cfg.gain_fast;
      end else if (mag > {1'b0, cfg.tier_mid, 8'h00}) begin
         gain = cfg.gain_mid;
      end else if (mag >= {1'b0, cfg.tier_low, 8'h00}) begin
         gain = cfg.gain_small;
      end else begin
         gain = cfg.gain_tiny;
      end
   end

   // gain step rounded half up, added to the state and saturated to 24 bits
   assign prod = diff * $signed({1'b0, gain});
   assign rnd  = prod + 35'sd128;
   assign step = rnd[34:8];
   assign sum  = {{4{fv_ff[23]}}, fv_ff} + {step[26], step};

   always_comb begin
      vld_in = vld_ff;
      fv_in  = fv_ff;
      if (pop) begin
         vld_in = 1'b1;
         priority if (sum > 28'sd8388607) begin
            fv_in = 24'sh7fffff;
         end else if (sum < -28'sd8388608) begin
            fv_in = 24'sh800000;
         end else begin
            fv_in = sum[23:0];
         end
      end else if (out_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         fv_ff  <= '0;
      end else begin
         vld_ff <= vld_in;
         fv_ff  <= fv_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_fv    = fv_ff;

   `AELCS_ASSERT_NXT(a_fv_hold, !in_valid || !in_ready, $stable(fv_ff), "filter state moved without a transfer")

endmodule

@@ rtl/aelcs_scale.sv @@
// back end output stage: offset, range check, clamp and mm scaling
// depends on aelcs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "adaptive_ema_loop_current_scaler_defines.svh"

module aelcs_scale (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [15:0]                     offset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [aelcs_pkg::FiltWidth-1:0] in_fv,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [aelcs_pkg::DistWidth-1:0]        out_dist,
   output aelcs_pkg::range_type                   out_status,
   output logic signed [15:0]                     out_current
);

   logic                              vld_ff, vld_in;
   logic [aelcs_pkg::DistWidth-1:0]   dist_ff, dist_in;
   aelcs_pkg::range_type              stat_ff, stat_in;
   logic signed [15:0]                cur_ff, cur_in;
   logic                              take;
   logic signed [24:0]                rnd;
   logic signed [17:0]                csum;
   logic signed [15:0]                cur;
   logic signed [15:0]                clamp;
   logic [12:0]                       span;
   logic [23:0]                       mm_prod;
   logic [23:0]                       mm_rnd;

   assign in_ready = !vld_ff || out_ready;
   assign take     = in_valid && in_ready;

   // q8.16 to q8.8 rounded, plus offset, saturated
   assign rnd  = {in_fv[23], in_fv} + 25'sd128;
   assign csum = {rnd[24], rnd[24:8]} + {{2{offset[15]}}, offset};

   always_comb begin
      priority if (csum > 18'sd32767) begin
         cur = 16'sh7fff;
      end else if (csum < -18'sd32768) begin
         cur = 16'sh8000;
      end else begin
         cur = csum[15:0];
      end
   end

   // clamp to the 4..20 ma span
   always_comb begin
      priority if (cur < aelcs_pkg::Q_SPAN_LOW) begin
         clamp = aelcs_pkg::Q_SPAN_LOW;
      end else if (cur >= aelcs_pkg::Q_SPAN_HIGH) begin
         clamp = aelcs_pkg::Q_SPAN_HIGH;
      end else begin
         clamp = cur;
      end
   end

   // linear map onto 100..2000 mm, halves rounded up
   assign span    = 13'(clamp - aelcs_pkg::Q_SPAN_LOW);
   assign mm_prod = span * aelcs_pkg::MM_SPAN;
   assign mm_rnd  = mm_prod + 24'd2048;

   // output register
   always_comb begin
      vld_in  = vld_ff;
      dist_in = dist_ff;
      stat_in = stat_ff;
      cur_in  = cur_ff;
      if (take) begin
         vld_in = 1'b1;
         cur_in = cur;
         priority if (cur < aelcs_pkg::Q_UNDER_LIMIT) begin
            dist_in = aelcs_pkg::MM_UNDER;
            stat_in = aelcs_pkg::RANGE_UNDER;
         end else if (cur > aelcs_pkg::Q_OVER_LIMIT) begin
            dist_in = aelcs_pkg::MM_OVER;
            stat_in = aelcs_pkg::RANGE_OVER;
         end else begin
            dist_in = aelcs_pkg::MM_LOW + mm_rnd[22:12];
            stat_in = aelcs_pkg::RANGE_OK;
         end
      end else if (out_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      dist_ff <= dist_in;
      stat_ff <= stat_in;
      cur_ff  <= cur_in;
   end

   assign out_valid   = vld_ff;
   assign out_dist    = dist_ff;
   assign out_status  = stat_ff;
   assign out_current = cur_ff;

   `AELCS_ASSERT_IMP(a_under_cur, vld_ff && stat_ff == aelcs_pkg::RANGE_UNDER, cur_ff < aelcs_pkg::Q_UNDER_LIMIT, "under-range with current in range")

endmodule

@@ rtl/adaptive_ema_loop_current_scaler.sv @@
// a req transfer reaches the matching rsp data through the input register, queue,
// filter state register and output register; throughput: one sample per cycle
// while rsp_tready is high; the filter loop (change, tier select, gain multiply,
// saturating add) closes on the filter state register
// reset: synchronous; clears all valids, the filtered value and sets csr defaults
`timescale 1ns / 1ps

module adaptive_ema_loop_current_scaler (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] current_sample
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] distance_mm, [12:11] range_status,
                                    // [28:13] filtered_current, [31:29] zero
   // configuration writes
   input  logic        csr_we,
   input  logic [aelcs_pkg::CsrAddrWidth-1:0] csr_addr,
   input  logic [15:0] csr_wdata
);

   aelcs_pkg::cfg_type cfg_ff, cfg_in;

   logic                                   fr_valid, fr_ready;
   logic signed [aelcs_pkg::FiltWidth-1:0] fr_x;
   logic                                   q_valid, q_ready;
   logic signed [aelcs_pkg::FiltWidth-1:0] q_x;
   logic                                   f_valid, f_ready;
   logic signed [aelcs_pkg::FiltWidth-1:0] f_fv;
   logic [aelcs_pkg::DistWidth-1:0]        dist_mm;
   aelcs_pkg::range_type                   status;
   logic signed [15:0]                     cur;

   // configuration register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            aelcs_pkg::CSR_TIER_HIGH:  cfg_in.tier_high  = csr_wdata;
            aelcs_pkg::CSR_TIER_MID:   cfg_in.tier_mid   = csr_wdata;
            aelcs_pkg::CSR_TIER_LOW:   cfg_in.tier_low   = csr_wdata;
            aelcs_pkg::CSR_GAIN_FAST:  cfg_in.gain_fast  = csr_wdata[8:0];
            aelcs_pkg::CSR_GAIN_MID:   cfg_in.gain_mid   = csr_wdata[8:0];
            aelcs_pkg::CSR_GAIN_SMALL: cfg_in.gain_small = csr_wdata[8:0];
            aelcs_pkg::CSR_GAIN_TINY:  cfg_in.gain_tiny  = csr_wdata[8:0];
            aelcs_pkg::CSR_OFFSET:     cfg_in.offset     = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= aelcs_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   aelcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sample (req_tdata),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_x     (fr_x)
   );

   // decoupling queue
   aelcs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_x      (fr_x),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_x     (q_x)
   );

   // back end: filter loop
   aelcs_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_x      (q_x),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_fv    (f_fv)
   );

   // back end: scaling and output register
   aelcs_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .offset      (cfg_ff.offset),
      .in_valid    (f_valid),
      .in_ready    (f_ready),
      .in_fv       (f_fv),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_dist    (dist_mm),
      .out_status  (status),
      .out_current (cur)
   );

   // result packing
   assign rsp_tdata = {3'b000, cur, status, dist_mm};

endmodule
